// ===== design/lhs_pkg.sv =====
`timescale 1ns / 1ps

package lhs_pkg;

  // Table geometry
  localparam int NUM_BINS   = 256;
  localparam int COUNT_BITS = 32;
  localparam int BIN_W      = $clog2(NUM_BINS);

  // Port field widths
  localparam int DATA_W      = 32;
  localparam int BIN_INDEX_W = 8;
  localparam int RAW_W       = 32;
  localparam int LOG_W       = 16;
  localparam int CFG_IDX_W   = 1;

  // Binning product: 32-bit difference times Q16.16 scale
  localparam int PROD_W     = 2 * DATA_W;
  localparam int SCALE_FRAC = 16;

  // log10 datapath
  localparam int X_W        = COUNT_BITS + 1;
  localparam int MANT_W     = 31;                       // Q1.30 mantissa
  localparam int MANT_FRAC  = MANT_W - 1;
  localparam int SQ_W       = 2 * MANT_W;
  localparam int NORM_W     = (X_W > MANT_W) ? X_W : MANT_W;
  localparam int NORM_STEPS = $clog2(NORM_W);
  localparam int EXP_W      = $clog2(NORM_W);
  localparam int LOG2_FRAC  = 20;
  localparam int L2_W       = EXP_W + LOG2_FRAC;
  localparam int K_W        = 32;
  localparam int LP_W       = L2_W + K_W;
  localparam int ROUND_SHIFT = LOG2_FRAC + K_W - 12;    // Q.20 * Q.32 down to Q.12
  localparam int ITER_W     = $clog2((LOG2_FRAC > NORM_STEPS) ? LOG2_FRAC : NORM_STEPS);

  localparam logic [K_W-1:0] LOG10_2_Q32 = 32'd1292913986;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [BIN_W-1:0]      bin_t;

  localparam count_t COUNT_MAX = '1;

  typedef enum logic {
    CMD_ADD  = 1'b0,
    CMD_READ = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VALUE_MINIMUM = 1'd0,
    REG_BIN_SCALE     = 1'd1
  } reg_idx_t;

  typedef struct packed {
    logic   rd;
    logic   wr;
    bin_t   addr;
    count_t wdata;
  } mem_cmd_t;

endpackage

// ===== design/lhs_in_if.sv =====
`timescale 1ns / 1ps

interface lhs_in_if;
  logic                                     valid;
  logic                                     ready;
  lhs_pkg::cmd_t                            cmd;
  logic signed [lhs_pkg::DATA_W-1:0]        sample;
  logic        [lhs_pkg::BIN_INDEX_W-1:0]   bin_index;

  modport source (output valid, cmd, sample, bin_index, input ready);
  modport sink   (input valid, cmd, sample, bin_index, output ready);
endinterface

// ===== design/lhs_out_if.sv =====
`timescale 1ns / 1ps

interface lhs_out_if;
  logic                                valid;
  logic                                ready;
  logic [lhs_pkg::BIN_INDEX_W-1:0]     bin_used;
  logic [lhs_pkg::RAW_W-1:0]           raw_count;
  logic [lhs_pkg::LOG_W-1:0]           log_count;
  logic                                clamped;
  logic                                count_saturated;

  modport source (output valid, bin_used, raw_count, log_count, clamped, count_saturated,
                  input ready);
  modport sink   (input valid, bin_used, raw_count, log_count, clamped, count_saturated,
                  output ready);
endinterface

// ===== design/lhs_count_mem.sv =====
`timescale 1ns / 1ps

module lhs_count_mem (
  input  logic              clk,
  input  logic              rst,
  input  lhs_pkg::mem_cmd_t cmd,
  output lhs_pkg::count_t   rdata
);

  lhs_pkg::count_t                 mem [lhs_pkg::NUM_BINS];
  logic [lhs_pkg::NUM_BINS-1:0]    valid;
  lhs_pkg::count_t                 rdata_raw;
  logic                            rvalid;

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[cmd.addr] <= cmd.wdata;
    end
    if (cmd.rd) begin
      rdata_raw <= mem[cmd.addr];
    end
  end

  // an entry never written since reset reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rvalid <= 1'b0;
    end else begin
      if (cmd.wr) begin
        valid[cmd.addr] <= 1'b1;
      end
      if (cmd.rd) begin
        rvalid <= valid[cmd.addr];
      end
    end
  end

  assign rdata = rvalid ? rdata_raw : '0;

endmodule

// ===== design/lhs_log10.sv =====
`timescale 1ns / 1ps

module lhs_log10 (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  lhs_pkg::count_t             count,
  output logic                        done,
  output logic [lhs_pkg::LOG_W-1:0]   result
);

  typedef enum logic [2:0] {
    L_IDLE,
    L_NORM,
    L_LEAD,
    L_SQUARE,
    L_SCALE,
    L_ROUND
  } state_t;

  state_t                            state;
  logic [lhs_pkg::NORM_W-1:0]        w;
  logic [lhs_pkg::EXP_W-1:0]         shift;
  logic [lhs_pkg::ITER_W-1:0]        iter;
  logic [lhs_pkg::MANT_W-1:0]        m;
  logic [lhs_pkg::L2_W-1:0]          l2;
  logic [lhs_pkg::LP_W-1:0]          lp;

  logic [lhs_pkg::EXP_W-1:0]         norm_amt;
  logic                              norm_take;
  logic [lhs_pkg::SQ_W-1:0]          sq;
  logic [lhs_pkg::MANT_W:0]          sq_top;
  logic [lhs_pkg::LP_W-1:0]          lp_round;
  logic [lhs_pkg::X_W-1:0]           x;

  always_comb begin
    x         = {1'b0, count} + lhs_pkg::X_W'(1);
    // binary search for the leading one, widest step first
    norm_amt  = lhs_pkg::EXP_W'(1) << (lhs_pkg::NORM_STEPS - 1 - int'(iter));
    norm_take = ((w >> (lhs_pkg::NORM_W - int'(norm_amt))) == '0);
    sq        = m * m;
    sq_top    = sq[lhs_pkg::SQ_W-1:lhs_pkg::MANT_FRAC];
    lp_round  = lp + (lhs_pkg::LP_W'(1) << (lhs_pkg::ROUND_SHIFT - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        L_IDLE: begin
          if (start) begin
            w     <= lhs_pkg::NORM_W'(x);
            shift <= '0;
            iter  <= '0;
            state <= L_NORM;
          end
        end
        L_NORM: begin
          if (norm_take) begin
            w     <= w << norm_amt;
            shift <= shift + norm_amt;
          end
          if (iter == lhs_pkg::ITER_W'(lhs_pkg::NORM_STEPS - 1)) begin
            state <= L_LEAD;
          end else begin
            iter <= iter + 1'b1;
          end
        end
        L_LEAD: begin
          m     <= w[lhs_pkg::NORM_W-1 -: lhs_pkg::MANT_W];
          l2    <= lhs_pkg::L2_W'(lhs_pkg::EXP_W'(lhs_pkg::NORM_W - 1) - shift);
          iter  <= '0;
          state <= L_SQUARE;
        end
        L_SQUARE: begin
          // one fraction bit of log2 per squaring
          if (sq_top[lhs_pkg::MANT_W]) begin
            m  <= sq_top[lhs_pkg::MANT_W:1];
            l2 <= {l2[lhs_pkg::L2_W-2:0], 1'b1};
          end else begin
            m  <= sq_top[lhs_pkg::MANT_W-1:0];
            l2 <= {l2[lhs_pkg::L2_W-2:0], 1'b0};
          end
          if (iter == lhs_pkg::ITER_W'(lhs_pkg::LOG2_FRAC - 1)) begin
            state <= L_SCALE;
          end else begin
            iter <= iter + 1'b1;
          end
        end
        L_SCALE: begin
          lp    <= l2 * lhs_pkg::LOG10_2_Q32;
          state <= L_ROUND;
        end
        L_ROUND: begin
          result <= lp_round[lhs_pkg::ROUND_SHIFT +: lhs_pkg::LOG_W];
          done   <= 1'b1;
          state  <= L_IDLE;
        end
        default: state <= L_IDLE;
      endcase
    end
  end

endmodule

// ===== design/log_scaled_histogram.sv =====
`timescale 1ns / 1ps

// Intensity histogram with log readout. Each transfer on req is an add (bin the sample
// as floor((sample - value_minimum) * bin_scale), Q16.16 scale, clamp into the table,
// bump the saturating count) or a read of bin_index; each yields one transfer on rsp
// with the bin, its count after the operation and log10(count + 1) in Q4.12. Items are
// handled one at a time: an add steps through S_MUL, S_BIN, S_READ, S_UPDATE, S_LOG and
// S_OUT, a read from S_READ on; the next item is accepted after S_OUT loads the result
// into the output register. The time is set mostly by the log unit, which runs six
// normalize steps and twenty squarings through its squaring multiplier. A new item is
// accepted while the previous result still waits on rsp. Counts sit in a 256-entry RAM
// with per-entry valid bits, so reset clears the table at once with no clearing pass.
// Registers (wr_index): 0 value_minimum (signed), 1 bin_scale (unsigned Q16.16);
// write them only while the block is idle.
module log_scaled_histogram (
  input  logic                              clk,
  input  logic                              rst,
  lhs_in_if.sink                            req,
  lhs_out_if.source                         rsp,
  input  logic                              wr_en,
  input  logic [lhs_pkg::CFG_IDX_W-1:0]     wr_index,
  input  logic [lhs_pkg::DATA_W-1:0]        wr_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_BIN,
    S_READ,
    S_UPDATE,
    S_LOG,
    S_OUT
  } state_t;

  state_t                                 state;
  logic signed [lhs_pkg::DATA_W-1:0]      value_minimum;
  logic        [lhs_pkg::DATA_W-1:0]      bin_scale;

  lhs_pkg::cmd_t                          cmd;
  logic signed [lhs_pkg::DATA_W:0]        diff;
  logic        [lhs_pkg::PROD_W-1:0]      prod;
  lhs_pkg::bin_t                          bin;
  logic                                   clamped;
  lhs_pkg::count_t                        cnt;

  lhs_pkg::mem_cmd_t                      mem_cmd;
  lhs_pkg::count_t                        mem_rdata;
  lhs_pkg::count_t                        cnt_next;
  logic                                   log_start;
  logic                                   log_done;
  logic [lhs_pkg::LOG_W-1:0]              log_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      value_minimum <= '0;
      bin_scale     <= '0;
    end else if (wr_en) begin
      unique case (lhs_pkg::reg_idx_t'(wr_index))
        lhs_pkg::REG_VALUE_MINIMUM: value_minimum <= wr_data;
        lhs_pkg::REG_BIN_SCALE:     bin_scale     <= wr_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cmd == lhs_pkg::CMD_ADD && mem_rdata != lhs_pkg::COUNT_MAX) begin
      cnt_next = mem_rdata + 1'b1;
    end else begin
      cnt_next = mem_rdata;
    end
    mem_cmd.rd    = (state == S_READ);
    mem_cmd.wr    = (state == S_UPDATE) && (cmd == lhs_pkg::CMD_ADD);
    mem_cmd.addr  = bin;
    mem_cmd.wdata = cnt_next;
    log_start     = (state == S_UPDATE);
  end

  assign req.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp.valid <= 1'b0;
    end else begin
      // in S_OUT a ready sink always sees the register reloaded below
      if (rsp.ready && state != S_OUT) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            cmd <= req.cmd;
            if (req.cmd == lhs_pkg::CMD_ADD) begin
              diff  <= {req.sample[lhs_pkg::DATA_W-1], req.sample}
                     - {value_minimum[lhs_pkg::DATA_W-1], value_minimum};
              state <= S_MUL;
            end else begin
              if (32'(req.bin_index) > 32'(lhs_pkg::NUM_BINS - 1)) begin
                bin     <= lhs_pkg::bin_t'(lhs_pkg::NUM_BINS - 1);
                clamped <= 1'b1;
              end else begin
                bin     <= lhs_pkg::bin_t'(req.bin_index);
                clamped <= 1'b0;
              end
              state <= S_READ;
            end
          end
        end
        S_MUL: begin
          // a nonnegative difference fits in 32 bits; negative ones are caught below
          prod  <= diff[lhs_pkg::DATA_W-1:0] * bin_scale;
          state <= S_BIN;
        end
        S_BIN: begin
          if (bin_scale == '0) begin
            bin     <= '0;
            clamped <= 1'b0;
          end else if (diff[lhs_pkg::DATA_W]) begin
            bin     <= '0;
            clamped <= 1'b1;
          end else if (prod[lhs_pkg::PROD_W-1:lhs_pkg::SCALE_FRAC]
                       > (lhs_pkg::PROD_W - lhs_pkg::SCALE_FRAC)'(lhs_pkg::NUM_BINS - 1)) begin
            bin     <= lhs_pkg::bin_t'(lhs_pkg::NUM_BINS - 1);
            clamped <= 1'b1;
          end else begin
            bin     <= prod[lhs_pkg::SCALE_FRAC +: lhs_pkg::BIN_W];
            clamped <= 1'b0;
          end
          state <= S_READ;
        end
        S_READ: begin
          state <= S_UPDATE;
        end
        S_UPDATE: begin
          cnt   <= cnt_next;
          state <= S_LOG;
        end
        S_LOG: begin
          if (log_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid           <= 1'b1;
            rsp.bin_used        <= lhs_pkg::BIN_INDEX_W'(bin);
            rsp.raw_count       <= lhs_pkg::RAW_W'(cnt);
            rsp.log_count       <= log_result;
            rsp.clamped         <= clamped;
            rsp.count_saturated <= (cnt == lhs_pkg::COUNT_MAX);
            state               <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  lhs_count_mem u_mem (
    .clk   (clk),
    .rst   (rst),
    .cmd   (mem_cmd),
    .rdata (mem_rdata)
  );

  lhs_log10 u_log (
    .clk    (clk),
    .rst    (rst),
    .start  (log_start),
    .count  (cnt_next),
    .done   (log_done),
    .result (log_result)
  );

endmodule
